### src/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/omq_pkg.sv
// Shared types and constants for the ordered matching queue.
`default_nettype none

package omq_pkg;

    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_HANDLE_WIDTH = 8;

    localparam int OP_W   = 2;
    localparam int TYPE_W = 2;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MATCH  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

`default_nettype wire

### src/omq_mem.sv
// Entry store: one write port, one read port, registered read data.
`default_nettype none

module omq_mem #(
    parameter int DEPTH  = omq_pkg::DEF_QUEUE_DEPTH,
    parameter int DATA_W = omq_pkg::DEF_HANDLE_WIDTH + omq_pkg::TYPE_W,
    parameter int ADDR_W = $clog2(omq_pkg::DEF_QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/ordered_matching_queue.sv
// Ordered matching queue: top level with the scan and compaction sequencer.
//
// Command port: an operation is taken at a rising edge where i_start is high
// and o_busy is low. Opcode push appends {handle, type}; remove deletes the
// oldest entry holding i_handle; match deletes the oldest entry of type
// i_msg_type and returns its handle; the spare opcode does nothing.
// Each command yields one result beat, shown for one cycle with o_valid high:
// status, found handle (zero unless a match succeeded) and occupancy.
// Push and the spare opcode: result in the cycle after acceptance, so one
// command per cycle. Remove and match walk the entries oldest first through
// the single read port of the entry store, one entry a cycle, and write each
// entry behind the hit back one place lower on the write port in the same
// pass: o_busy stays high for the scan and the result beat is shown in the
// cycle in which o_busy is low again, or in the cycle after acceptance for
// an empty queue. Reset empties the queue; entry contents are not cleared.
// The receiver cannot stall: each result beat lasts one cycle.
`default_nettype none

module ordered_matching_queue #(
    parameter int QUEUE_DEPTH  = omq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_WIDTH = omq_pkg::DEF_HANDLE_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [omq_pkg::OP_W-1:0]            i_opcode,
    input  wire logic [HANDLE_WIDTH-1:0]             i_handle,
    input  wire logic [omq_pkg::TYPE_W-1:0]          i_msg_type,
    output logic                                     o_busy,
    output logic                                     o_valid,
    output logic [omq_pkg::ST_W-1:0]                 o_status,
    output logic [HANDLE_WIDTH-1:0]                  o_found_handle,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         o_occupancy
);

    import omq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = HANDLE_WIDTH + TYPE_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_cnt;
    t_op                     r_op;
    logic [HANDLE_WIDTH-1:0] r_key_handle;
    logic [TYPE_W-1:0]       r_key_type;
    logic [CW-1:0]           r_rd_idx;
    logic                    r_rv;
    logic [IW-1:0]           r_pos;
    logic                    r_hit;
    logic [HANDLE_WIDTH-1:0] r_found;
    logic                    r_valid;
    t_status                 r_status;
    logic [HANDLE_WIDTH-1:0] r_found_out;
    logic [CW-1:0]           r_occ;

    logic                    rd_issue;
    logic [IW-1:0]           rd_addr;
    logic [DW-1:0]           rd_data;
    logic [HANDLE_WIDTH-1:0] d_handle;
    logic [TYPE_W-1:0]       d_type;
    logic                    cmp;
    logic                    last;
    logic                    do_push;
    logic                    we;
    logic [IW-1:0]           waddr;
    logic [DW-1:0]           wdata;

    assign rd_issue = (r_state == S_SCAN) && (r_rd_idx < r_cnt);
    assign rd_addr  = r_rd_idx[IW-1:0];
    assign d_handle = rd_data[DW-1:TYPE_W];
    assign d_type   = rd_data[TYPE_W-1:0];
    assign cmp      = (r_op == OP_REMOVE) ? (d_handle == r_key_handle)
                                          : (d_type == r_key_type);
    assign last     = (r_pos == IW'(r_cnt - CW'(1)));
    assign do_push  = (r_state == S_IDLE) && i_start && (t_op'(i_opcode) == OP_PUSH)
                      && (r_cnt != CW'(QUEUE_DEPTH));

    // Write port: push in idle, compaction during the scan. Compaction writes
    // always land below the read pointer, so no entry is read after being moved.
    always_comb begin
        we    = 1'b0;
        waddr = r_cnt[IW-1:0];
        wdata = {i_handle, i_msg_type};
        if (do_push) begin
            we = 1'b1;
        end else if ((r_state == S_SCAN) && r_rv && r_hit) begin
            we    = 1'b1;
            waddr = r_pos - IW'(1);
            wdata = rd_data;
        end
    end

    omq_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (DW),
        .ADDR_W (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_rv    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op         <= t_op'(i_opcode);
                        r_key_handle <= i_handle;
                        r_key_type   <= i_msg_type;
                        r_found_out  <= '0;
                        case (t_op'(i_opcode)) inside
                            OP_PUSH: begin
                                r_valid <= 1'b1;
                                if (do_push) begin
                                    r_cnt    <= r_cnt + CW'(1);
                                    r_occ    <= r_cnt + CW'(1);
                                    r_status <= ST_OK;
                                end else begin
                                    r_occ    <= r_cnt;
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_REMOVE, OP_MATCH: begin
                                if (r_cnt == '0) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_NOT_FOUND;
                                    r_occ    <= r_cnt;
                                end else begin
                                    r_state  <= S_SCAN;
                                    r_rd_idx <= '0;
                                    r_rv     <= 1'b0;
                                    r_hit    <= 1'b0;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_OK;
                                r_occ    <= r_cnt;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rv <= rd_issue;
                    if (rd_issue) begin
                        r_pos    <= rd_addr;
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    if (r_rv) begin
                        if (!r_hit && cmp) begin
                            r_hit   <= 1'b1;
                            r_found <= d_handle;
                        end
                        if (last) begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                            r_rv    <= 1'b0;
                            if (r_hit || cmp) begin
                                r_status <= ST_OK;
                                r_cnt    <= r_cnt - CW'(1);
                                r_occ    <= r_cnt - CW'(1);
                                if (r_op == OP_MATCH) begin
                                    r_found_out <= r_hit ? r_found : d_handle;
                                end else begin
                                    r_found_out <= '0;
                                end
                            end else begin
                                r_status    <= ST_NOT_FOUND;
                                r_occ       <= r_cnt;
                                r_found_out <= '0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_handle = r_found_out;
    assign o_occupancy    = r_occ;

endmodule

`default_nettype wire

### src/omq_checker.sv
// Port-level checker for the ordered matching queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module omq_checker #(
    parameter int QUEUE_DEPTH  = omq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_WIDTH = omq_pkg::DEF_HANDLE_WIDTH
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_start,
    input wire logic [omq_pkg::OP_W-1:0]    i_opcode,
    input wire logic                        o_busy,
    input wire logic                        o_valid,
    input wire logic [omq_pkg::ST_W-1:0]    o_status,
    input wire logic [HANDLE_WIDTH-1:0]     o_found_handle,
    input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] o_occupancy
);

    import omq_pkg::*;

    logic acc_quick;
    logic acc_scan;

    assign acc_quick = i_rst_n && i_start && !o_busy
                       && ((i_opcode == OP_PUSH) || (i_opcode == OP_NOP));
    assign acc_scan  = i_rst_n && i_start && !o_busy
                       && ((i_opcode == OP_REMOVE) || (i_opcode == OP_MATCH));

    // a result beat is only ever shown once the sequencer is free again
    `OMQ_ASSERT_NOW(a_valid_not_busy, i_clk, i_rst_n, o_valid, !o_busy, "result while busy")

    `OMQ_ASSERT_NOW(a_occ_range, i_clk, i_rst_n, o_valid,
        o_occupancy <= QUEUE_DEPTH, "occupancy above depth")

    `OMQ_ASSERT_NOW(a_found_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK),
        o_found_handle == '0, "handle reported on failure")

    `OMQ_ASSERT_NEXT(a_quick_resp, i_clk, i_rst_n, acc_quick, o_valid && !o_busy,
        "push or no-op did not answer next cycle")

    `OMQ_ASSERT_NEXT(a_scan_progress, i_clk, i_rst_n, acc_scan, o_valid || o_busy,
        "search command dropped")

endmodule

bind ordered_matching_queue omq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
) u_omq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .i_opcode       (i_opcode),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_found_handle (o_found_handle),
    .o_occupancy    (o_occupancy)
);

`default_nettype wire
